FILE: rtl/spa_pkg.sv
package spa_pkg;

	typedef struct packed {
		logic       mode;
		logic [7:0] kind;
		logic       target_valid;
		logic [5:0] slot;
	} req_t;

	typedef struct packed {
		logic       status;
		logic [5:0] granted_slot;
		logic [6:0] live_count;
		logic       pool_empty;
	} res_t;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	localparam logic STATUS_DONE   = 1'b0;
	localparam logic STATUS_REJECT = 1'b1;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

FILE: rtl/slot_pool_allocator.sv
// Slot pool allocator. A request (allocate or release) is taken at a clock edge where start
// is high and busy is low. Its result shows on result, marked by done high for exactly one
// cycle, passing through the EXEC state and then the done and result registers; nothing can
// hold it back, so the receiver must take it then. No new request is taken while busy is
// high: the accepting edge reads the live mark, position map, list tail and free stack
// memories, and the EXEC state writes them back; busy stays high across that read-modify-write.
// After reset slots are handed out from 0 upward; a counter of never-used slots stands in
// for the initial free stack contents, so the memories need no clearing pass and the block
// is ready as soon as reset is released. Released slots are handed out again last-in first-out.
// granted_slot and live_count carry the low bits of the slot number and of the live count.
module slot_pool_allocator import spa_pkg::*; #(
	parameter int SLOTS      = 64,
	parameter int KIND_BOUND = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t request,
	output logic busy,
	output logic done,
	output res_t result
);

	localparam int SW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	state_t state_q, state_d;
	req_t   req_s1;
	logic   take, exec;

	logic [CW-1:0] total_q, pushed_q, fresh_q, total_next;

	logic [SW-1:0] stack_rd, list_rd, pos_rd;
	logic          live_rd;

	logic          alloc_ok, rel_ok;
	logic [SW-1:0] new_slot, rel_slot;

	logic          done_q;
	res_t          result_q, res_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_EXEC;
			end
			ST_EXEC: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		unique case (state_q)
			ST_EXEC: begin
				busy = 1'b1;
				exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
				exec = 1'b0;
			end
		endcase
	end

	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) req_s1 <= request;
	end

	// decide the request from the data read at the accepting edge
	assign new_slot = (pushed_q != '0) ? stack_rd : SW'(fresh_q);
	assign rel_slot = SW'(req_s1.slot);

	// a slot at or above the never-used count was never written: treat it as not live
	assign alloc_ok = exec && (req_s1.mode == MODE_ALLOC) && (32'(req_s1.kind) < KIND_BOUND)
		&& req_s1.target_valid && ((pushed_q != '0) || (32'(fresh_q) != SLOTS));
	assign rel_ok   = exec && (req_s1.mode == MODE_RELEASE)
		&& (32'(req_s1.slot) < 32'(fresh_q)) && live_rd;

	always_comb begin
		priority if (alloc_ok) begin
			total_next = total_q + CW'(1);
		end else if (rel_ok) begin
			total_next = total_q - CW'(1);
		end else begin
			total_next = total_q;
		end
	end

	always_comb begin
		res_d.status       = (alloc_ok || rel_ok) ? STATUS_DONE : STATUS_REJECT;
		res_d.granted_slot = alloc_ok ? 6'(new_slot) : '0;
		res_d.live_count   = 7'(total_next);
		res_d.pool_empty   = (total_next == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			pushed_q <= '0;
			fresh_q  <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q  <= exec;
			total_q <= total_next;
			if (alloc_ok) begin
				if (pushed_q != '0) begin
					pushed_q <= pushed_q - CW'(1);
				end else begin
					fresh_q <= fresh_q + CW'(1);
				end
			end else if (rel_ok) begin
				pushed_q <= pushed_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec) result_q <= res_d;
	end

	assign done   = done_q;
	assign result = result_q;

	// free stack above the never-used slots: pop on allocate, push on release
	spa_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_stack_ram (
		.clk     (clk),
		.wr_en   (rel_ok),
		.wr_addr (SW'(pushed_q)),
		.wr_data (rel_slot),
		.rd_addr (SW'(pushed_q - CW'(1))),
		.rd_data (stack_rd)
	);

	spa_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_live_ram (
		.clk     (clk),
		.wr_en   (alloc_ok || rel_ok),
		.wr_addr (alloc_ok ? new_slot : rel_slot),
		.wr_data (alloc_ok),
		.rd_addr (SW'(request.slot)),
		.rd_data (live_rd)
	);

	// append on allocate; on release move the tail entry into the hole
	spa_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_list_ram (
		.clk     (clk),
		.wr_en   (alloc_ok || rel_ok),
		.wr_addr (alloc_ok ? SW'(total_q) : pos_rd),
		.wr_data (alloc_ok ? new_slot : list_rd),
		.rd_addr (SW'(total_q - CW'(1))),
		.rd_data (list_rd)
	);

	spa_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_pos_ram (
		.clk     (clk),
		.wr_en   (alloc_ok || rel_ok),
		.wr_addr (alloc_ok ? new_slot : list_rd),
		.wr_data (alloc_ok ? SW'(total_q) : pos_rd),
		.rd_addr (SW'(request.slot)),
		.rd_data (pos_rd)
	);

	// every slot is either live, on the pushed part of the stack, or never used
	a_count_balance: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, total_q} + {1'b0, pushed_q}) == {1'b0, fresh_q})
		else $error("live and pushed counts do not add up to used slots");

	a_take_then_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy ##1 (done && !busy))
		else $error("request not answered two cycles after it was taken");

	a_no_grant_and_release: assert property (@(posedge clk) disable iff (!arst_n)
		!(alloc_ok && rel_ok))
		else $error("allocate and release decided together");

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in progress");

endmodule

FILE: rtl/spa_ram.sv
module spa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
